/* sv/cnv_pkg.sv */
// Shared types and fixed constants for the 7x7 convolution stream.
// No dependencies; imported by cnv_cell and conv7x7_relu_stream.

package cnv_pkg;

    localparam int COORD_W    = 6;
    localparam int FEATURE_W  = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int WIDX_W     = 6;
    localparam int PHASE_W    = 2;
    localparam logic [PHASE_W-1:0] LAST_PHASE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_HEIGHT  = 2'd2,
        REG_NONE    = 2'd3
    } cfg_reg_t;

    // Per-cycle controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic adv;
        logic rd_en;
        logic wr_en;
        logic wt_en;
    } cnv_ctrl_t;

endpackage

/* sv/cnv_cell.sv */
// One kernel-row cell: line buffer row (when HAS_MEM), window row, weights and row products.
// Depends on cnv_pkg.

module cnv_cell
    import cnv_pkg::*;
#(
    parameter int KERNEL      = 7,
    parameter int MAX_WIDTH   = 64,
    parameter int PIXEL_BITS  = 8,
    parameter int WEIGHT_BITS = 16,
    parameter int ROW         = 0,
    parameter bit HAS_MEM     = 1'b1
)
(
    input  logic                                   clk,
    input  cnv_ctrl_t                              ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]           wr_addr,
    input  logic [PIXEL_BITS-1:0]                  feed,
    input  logic [WIDX_W-1:0]                      wt_idx,
    input  logic signed [WEIGHT_BITS-1:0]          wt_val,
    output logic [PIXEL_BITS-1:0]                  col_data,
    output logic signed [PIXEL_BITS+WEIGHT_BITS+$clog2(KERNEL):0] row_sum
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int PROD_W = PIXEL_BITS + WEIGHT_BITS + 1;
    localparam int ROW_W  = PROD_W + $clog2(KERNEL);

    logic [PIXEL_BITS-1:0]         win_reg  [KERNEL];
    logic signed [WEIGHT_BITS-1:0] wt_reg   [KERNEL];
    logic signed [PROD_W-1:0]      prod_reg [KERNEL];
    logic signed [ROW_W-1:0]       sum_reg;
    logic signed [ROW_W-1:0]       sum_next;

    generate
        if (HAS_MEM) begin : g_mem
            logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
            logic [PIXEL_BITS-1:0] rd_reg;

            // The read leads the write by one request; consecutive pixels
            // never share a column, so no bypass is needed.
            always_ff @(posedge clk)
            begin
                if (ctrl.adv && ctrl.rd_en)
                begin
                    rd_reg <= mem[rd_addr];
                end
                if (ctrl.adv && ctrl.wr_en)
                begin
                    mem[wr_addr] <= feed;
                end
            end
            assign col_data = rd_reg;
        end else begin : g_nomem
            assign col_data = (rd_addr == wr_addr) ? feed : feed;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            if (ctrl.wr_en)
            begin
                for (int c = 0; c < KERNEL - 1; c++)
                begin
                    win_reg[c] <= win_reg[c+1];
                end
                win_reg[KERNEL-1] <= col_data;
            end
            for (int c = 0; c < KERNEL; c++)
            begin
                if (ctrl.wt_en && (32'(wt_idx) == ROW * KERNEL + c))
                begin
                    wt_reg[c] <= wt_val;
                end
                prod_reg[c] <= $signed({1'b0, win_reg[c]}) * wt_reg[c];
            end
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int c = 0; c < KERNEL; c++)
        begin
            sum_next = sum_next + ROW_W'(prod_reg[c]);
        end
    end

    assign row_sum = sum_reg;

endmodule

/* sv/conv7x7_relu_stream.sv */
// Top level of the 7x7 valid convolution with ReLU over one RGB channel.
// Depends on cnv_pkg and cnv_cell.
//
// Usage:
//   The item channel (item_valid/item_stall) carries either one channel byte
//   of an interleaved RGB raster stream (kind 0) or one kernel weight load
//   (kind 1). One request is taken per clock while the result side is not
//   stalled. Only bytes of the selected channel advance the image position.
//   The result channel (result_valid/result_stall) gives one feature value
//   per window position that lies wholly inside the image, with its row and
//   column; frame_last marks the final output of a frame.
//   An accepted pixel passes through the s1 registers, the window, product
//   and row-sum registers of the cells and the output register; throughput is
//   one request per cycle while not stalled, set by the row cells advancing together.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   item_stall is raised until the result is taken.
//   Reset clears the counters, the channel phase and the configuration
//   (channel 0, 60 by 60); weights and line buffers hold nothing defined
//   until written. Configuration is written through cfg_valid/cfg_ready,
//   which is always ready.

module conv7x7_relu_stream
    import cnv_pkg::*;
#(
    parameter int MAX_WIDTH   = 64,
    parameter int KERNEL      = 7,
    parameter int PIXEL_BITS  = 8,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          kind,
    input  logic [PIXEL_BITS-1:0]         sample,
    input  logic [WIDX_W-1:0]             weight_index,
    input  logic signed [WEIGHT_BITS-1:0] weight_value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [FEATURE_W-1:0]          feature_value,
    output logic [COORD_W-1:0]            out_row,
    output logic [COORD_W-1:0]            out_col,
    output logic                          frame_last
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int PROD_W = PIXEL_BITS + WEIGHT_BITS + 1;
    localparam int ROW_W  = PROD_W + $clog2(KERNEL);
    localparam int SUM_W  = ROW_W + $clog2(KERNEL);

    // Configuration.
    logic [PHASE_W-1:0]    chan_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    // Stream position.
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic             adv, take, is_pix, emit, last;

    // Pipeline stages.
    logic                          s1_pix_reg, s1_emit_reg, s1_last_reg, s1_wt_reg;
    logic [CNT_W-1:0]              s1_col_reg, s1_row_reg;
    logic [PIXEL_BITS-1:0]         s1_pix_data;
    logic [WIDX_W-1:0]             s1_widx;
    logic signed [WEIGHT_BITS-1:0] s1_wval;
    logic                          s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic                          s2_last, s3_last, s4_last;
    logic [CNT_W-1:0]              s2_col, s2_row, s3_col, s3_row, s4_col, s4_row;
    logic [CNT_W-1:0]              row_off, col_off;

    logic                          out_vld_reg;
    logic [FEATURE_W-1:0]          feat_reg;
    logic [COORD_W-1:0]            orow_reg, ocol_reg;
    logic                          olast_reg;

    cnv_ctrl_t             ctrl;
    logic [PIXEL_BITS-1:0] col_data [KERNEL];
    logic signed [ROW_W-1:0] row_sums [KERNEL];
    logic signed [SUM_W-1:0] total;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (32'(v) < KERNEL)
        begin
            r = DIM_W'(KERNEL);
        end else if (32'(v) > MAX_WIDTH)
        begin
            r = DIM_W'(MAX_WIDTH);
        end else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    assign cfg_ready  = 1'b1;
    assign adv        = !(out_vld_reg && result_stall);
    assign item_stall = !adv;
    assign take       = item_valid && adv;
    assign w_eff      = clamp_dim(width_reg);
    assign h_eff      = clamp_dim(height_reg);
    assign is_pix     = take && !kind && (phase_reg == chan_reg);

    always_comb
    begin
        emit = (32'(col_reg) >= KERNEL - 1) && (32'(row_reg) >= KERNEL - 1)
            && (DIM_W'(col_reg) < w_eff) && (DIM_W'(row_reg) < h_eff);
        last = (DIM_W'(row_reg) == h_eff - DIM_W'(1))
            && (DIM_W'(col_reg) == w_eff - DIM_W'(1));
        phase_next = (phase_reg >= LAST_PHASE) ? '0 : phase_reg + PHASE_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (DIM_W'(col_reg) >= w_eff - DIM_W'(1))
        begin
            col_next = '0;
            if (DIM_W'(row_reg) >= h_eff - DIM_W'(1))
            begin
                row_next = '0;
            end else
            begin
                row_next = row_reg + CNT_W'(1);
            end
        end else
        begin
            col_next = col_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg   <= '0;
            width_reg  <= CFG_DATA_W'(60);
            height_reg <= CFG_DATA_W'(60);
        end else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CHANNEL: chan_reg   <= cfg_data[PHASE_W-1:0];
                REG_WIDTH:   width_reg  <= cfg_data;
                REG_HEIGHT:  height_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            s1_pix_reg  <= 1'b0;
            s1_emit_reg <= 1'b0;
            s1_wt_reg   <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv)
        begin
            if (take && !kind)
            begin
                phase_reg <= phase_next;
            end
            if (is_pix)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_pix_reg  <= is_pix;
            s1_emit_reg <= is_pix && emit;
            s1_wt_reg   <= take && kind;
            s2_vld_reg  <= s1_emit_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            out_vld_reg <= s4_vld_reg;
        end
    end

    assign row_off = s4_row - CNT_W'(KERNEL - 1);
    assign col_off = s4_col - CNT_W'(KERNEL - 1);

    always_comb
    begin
        total = '0;
        for (int r = 0; r < KERNEL; r++)
        begin
            total = total + SUM_W'(row_sums[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_last_reg <= last;
            s1_pix_data <= sample;
            s1_widx     <= weight_index;
            s1_wval     <= weight_value;
            s2_col      <= s1_col_reg;
            s2_row      <= s1_row_reg;
            s2_last     <= s1_last_reg;
            s3_col      <= s2_col;
            s3_row      <= s2_row;
            s3_last     <= s2_last;
            s4_col      <= s3_col;
            s4_row      <= s3_row;
            s4_last     <= s3_last;
            feat_reg    <= total[SUM_W-1] ? '0 : FEATURE_W'(total);
            orow_reg    <= COORD_W'(row_off);
            ocol_reg    <= COORD_W'(col_off);
            olast_reg   <= s4_last;
        end
    end

    always_comb
    begin
        ctrl.adv   = adv;
        ctrl.rd_en = is_pix;
        ctrl.wr_en = s1_pix_reg;
        ctrl.wt_en = s1_wt_reg;
    end

    // Cell r reads its line row and hands it down to cell r-1; the bottom
    // cell takes the incoming pixel.
    assign col_data[KERNEL-1] = s1_pix_data;

    genvar gr;
    generate
        for (gr = 0; gr < KERNEL; gr++)
        begin : g_cell
            if (gr < KERNEL - 1)
            begin : g_buf
                cnv_cell #(
                    .KERNEL(KERNEL), .MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS),
                    .WEIGHT_BITS(WEIGHT_BITS), .ROW(gr), .HAS_MEM(1'b1)
                ) u_cell (
                    .clk(clk), .ctrl(ctrl), .rd_addr(col_reg), .wr_addr(s1_col_reg),
                    .feed(col_data[gr+1]), .wt_idx(s1_widx), .wt_val(s1_wval),
                    .col_data(col_data[gr]), .row_sum(row_sums[gr])
                );
            end else
            begin : g_last
                logic [PIXEL_BITS-1:0] unused_data;
                cnv_cell #(
                    .KERNEL(KERNEL), .MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS),
                    .WEIGHT_BITS(WEIGHT_BITS), .ROW(gr), .HAS_MEM(1'b0)
                ) u_cell (
                    .clk(clk), .ctrl(ctrl), .rd_addr(col_reg), .wr_addr(s1_col_reg),
                    .feed(s1_pix_data), .wt_idx(s1_widx), .wt_val(s1_wval),
                    .col_data(unused_data), .row_sum(row_sums[gr])
                );
            end
        end
    endgenerate

    assign result_valid  = out_vld_reg;
    assign feature_value = feat_reg;
    assign out_row       = orow_reg;
    assign out_col       = ocol_reg;
    assign frame_last    = olast_reg;

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= LAST_PHASE)
        else $error("channel phase out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < MAX_WIDTH) && (32'(row_reg) < MAX_WIDTH))
        else $error("stream position out of range");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({s1_pix_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg}))
        else $error("pipeline moved while the result was stalled");

    a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && result_stall) |=> $stable({col_reg, row_reg, phase_reg}))
        else $error("stream position moved under stall");
`endif

endmodule

/* tb/tb_conv7x7_relu_stream.sv */
// Self-checking testbench for conv7x7_relu_stream: streams whole RGB frames and
// weight loads, predicts each feature output and checks it against the block.
// Depends on cnv_pkg and the conv7x7_relu_stream RTL.

module tb_conv7x7_relu_stream;
    import cnv_pkg::*;

    localparam int K        = 7;
    localparam int MAXW     = 64;
    localparam int TAPS     = K * K;
    localparam int LIMIT    = 400000;
    localparam int SETTLE   = 12;
    localparam int IDLE_PCT = 22;

    typedef struct {
        logic              kind;
        logic [7:0]        sample;
        logic [5:0]        widx;
        logic signed [15:0] wval;
    } stream_req_t;

    typedef struct {
        logic [FEATURE_W-1:0] value;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic                 last;
    } feature_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CHANNEL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic kind = 1'b0;
    logic [7:0] sample = '0;
    logic [WIDX_W-1:0] weight_index = '0;
    logic signed [15:0] weight_value = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [FEATURE_W-1:0] feature_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic frame_last;

    stream_req_t pending_reqs[$];
    feature_t    expected_features[$];
    int          errors = 0;
    int          cycles = 0;
    int          pushed = 0;
    bit          took = 1'b0;
    bit          calm = 1'b0;

    // Predictor state.
    logic [7:0]         line_mem[K-1][MAXW];
    logic [7:0]         win[K][K];
    logic signed [15:0] kern[TAPS];
    int                 col_cnt, row_cnt, phase;
    int                 sel_ch, img_w, img_h;

    conv7x7_relu_stream DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_dim(int v);
        if (v < K) return K;
        if (v > MAXW) return MAXW;
        return v;
    endfunction

    function automatic void predict_feature(stream_req_t rq);
        logic [7:0] column[K];
        int w, h, c;
        longint acc;
        feature_t f;
        if (rq.kind)
        begin
            if (rq.widx < TAPS) kern[rq.widx] = rq.wval;
            return;
        end
        if (phase != sel_ch)
        begin
            phase = (phase >= 2) ? 0 : phase + 1;
            return;
        end
        phase = (phase >= 2) ? 0 : phase + 1;
        w = clamp_dim(img_w);
        h = clamp_dim(img_h);
        c = col_cnt % MAXW;
        for (int r = 0; r < K - 1; r++) column[r] = line_mem[r][c];
        column[K-1] = rq.sample;
        for (int r = 0; r < K - 2; r++) line_mem[r][c] = line_mem[r+1][c];
        line_mem[K-2][c] = rq.sample;
        for (int r = 0; r < K; r++)
        begin
            for (int j = 0; j < K - 1; j++) win[r][j] = win[r][j+1];
            win[r][K-1] = column[r];
        end
        if (c >= K - 1 && row_cnt >= K - 1 && c < w && row_cnt < h)
        begin
            acc = 0;
            for (int r = 0; r < K; r++)
                for (int j = 0; j < K; j++)
                    acc += longint'(win[r][j]) * longint'(kern[r*K + j]);
            if (acc < 0) acc = 0;
            f.value = acc[FEATURE_W-1:0];
            f.row   = COORD_W'(row_cnt - (K - 1));
            f.col   = COORD_W'(c - (K - 1));
            f.last  = (row_cnt == h - 1 && c == w - 1);
            expected_features.push_back(f);
        end
        if (col_cnt >= w - 1)
        begin
            col_cnt = 0;
            row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
        end
        else
        begin
            col_cnt++;
        end
    endfunction

    // Monitor: predicts on every accepted request and checks every result.
    always @(posedge clk)
    begin
        feature_t e;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        took = item_valid && !item_stall;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CHANNEL: sel_ch = cfg_data & 3;
                REG_WIDTH:   img_w = cfg_data;
                REG_HEIGHT:  img_h = cfg_data;
                default: ;
            endcase
        end
        if (rst_n && took)
            predict_feature('{kind, sample, weight_index, weight_value});
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_features.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result value=%0d row=%0d col=%0d last=%0b",
                         $time, feature_value, out_row, out_col, frame_last);
            end
            else
            begin
                e = expected_features.pop_front();
                if (e.value !== feature_value || e.row !== out_row ||
                    e.col !== out_col || e.last !== frame_last)
                begin
                    errors++;
                    $display("%0t: mismatch expected value=%0d row=%0d col=%0d last=%0b",
                             $time, e.value, e.row, e.col, e.last);
                    $display("%0t:          actual   value=%0d row=%0d col=%0d last=%0b",
                             $time, feature_value, out_row, out_col, frame_last);
                end
            end
        end
    end

    // Driver: presents queued requests, idling and stalling results at random unless calm.
    always @(negedge clk)
    begin
        stream_req_t rq;
        result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        if (rst_n && (!item_valid || took))
        begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                rq = pending_reqs.pop_front();
                item_valid   <= 1'b1;
                kind         <= rq.kind;
                sample       <= rq.sample;
                weight_index <= rq.widx;
                weight_value <= rq.wval;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    task automatic push_weight(int idx, int val);
        stream_req_t rq;
        rq.kind = 1'b1;
        rq.sample = 8'($urandom);
        rq.widx = 6'(idx);
        rq.wval = 16'(val);
        pending_reqs.push_back(rq);
        pushed++;
    endtask

    // Queues a whole frame of RGB pixels; style 1 saturates, 2 blanks the bytes.
    task automatic push_frame(int w, int h, int style);
        stream_req_t rq;
        for (int p = 0; p < 3 * w * h; p++)
        begin
            rq.kind = 1'b0;
            rq.widx = 6'($urandom);
            rq.wval = 16'($urandom);
            rq.sample = (style == 1) ? 8'hff : (style == 2) ? 8'h00 : 8'($urandom);
            pending_reqs.push_back(rq);
            pushed++;
            // A weight update now and then, the odd one to an unused index.
            if ($urandom_range(199) == 0)
                push_weight($urandom_range(99) < 80 ? $urandom_range(TAPS - 1)
                                                    : $urandom_range(63, TAPS),
                            $urandom_range(65535));
        end
    endtask

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && !item_valid);
        wait (expected_features.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int ch, int w, int h);
        wait_idle();
        write_reg(REG_CHANNEL, ch);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    initial
    begin
        int ch, w, h, frames;
        col_cnt = 0; row_cnt = 0; phase = 0;
        sel_ch = 0; img_w = 60; img_h = 60;
        foreach (kern[i]) kern[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme weights, ignored indexes, a saturated frame and a
        // frame on channel three with a height below the minimum.
        for (int i = 0; i < TAPS; i++) push_weight(i, 32767);
        push_weight(TAPS, -32768);
        push_weight(63, 0);
        configure(0, 7, 7);
        push_frame(7, 7, 1);
        push_weight(24, -32768);
        push_weight(0, 0);
        configure(3, 7, 0);
        push_frame(7, 7, 0);

        // Random frames; the first is full width, clamped from an oversized
        // value, with fresh weights and no idling.
        frames = 0;
        while (pushed < 1550 || frames < 1)
        begin
            ch = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
            if (frames == 0)
            begin
                w = 127;
                h = 7;
                ch = $urandom_range(2);
            end
            else if ($urandom_range(9) == 0)
            begin
                w = $urandom_range(6);
                h = $urandom_range(6);
                ch = 0;
            end
            else
            begin
                w = $urandom_range(7, 10);
                h = $urandom_range(7, 9);
            end
            configure(ch, w, h);
            calm = (frames == 0);
            if (frames == 0 || $urandom_range(3) == 0)
                for (int i = 0; i < TAPS; i++)
                    push_weight(i, $urandom_range(1) ? $urandom_range(65535)
                                                     : $urandom_range(2000));
            push_frame(clamp_dim(w), clamp_dim(h), 0);
            frames++;
        end
        wait_idle();
        calm = 1'b0;
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
sv/cnv_pkg.sv
sv/cnv_cell.sv
sv/conv7x7_relu_stream.sv
tb/tb_conv7x7_relu_stream.sv
